### hw/rtl/mlhs_pkg.sv
package mlhs_pkg;

  localparam int unsigned HistoryBytesDef = 512;
  localparam int unsigned LineMaxDef      = 64;
  localparam int unsigned MaxResults      = 63;

  localparam logic [6:0] CapReset = 7'd64;

  // request codes
  localparam logic [1:0] REQ_STAGE  = 2'd0;
  localparam logic [1:0] REQ_COMMIT = 2'd1;
  localparam logic [1:0] REQ_FETCH  = 2'd2;

  // commit status codes
  localparam logic [1:0] ST_EMPTY = 2'd0;
  localparam logic [1:0] ST_DUP   = 2'd1;
  localparam logic [1:0] ST_INS   = 2'd2;

  typedef struct packed {
    logic [1:0] req_type;
    logic [6:0] line_byte;
    logic [8:0] entry_index;
  } in_item_t;

  typedef struct packed {
    logic [6:0] out_byte;
    logic       found;
    logic [1:0] commit_status;
    logic       last;
  } out_item_t;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_CLR,
    OP_LATCH,
    OP_SC_INIT,
    OP_SC_RD,
    OP_SC_EV,
    OP_DUP_INIT,
    OP_INS_INIT,
    OP_SH_RD,
    OP_SH_WR,
    OP_ZT,
    OP_ZS,
    OP_CP_RD,
    OP_CP_WR,
    OP_C_RES,
    OP_F_INIT,
    OP_RD_P,
    OP_P_INC,
    OP_F_NEXT,
    OP_NF_RES,
    OP_E_TAKE,
    OP_E_PUSH,
    OP_E_LAST,
    OP_E_EMPTY
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic [1:0] req;
    logic       slen_zero;
    logic       fill_zero;
    logic       idx_zero;
    logic       sc_match;
    logic       sc_end;
    logic       sh_go;
    logic       sh_last;
    logic       dup;
    logic       cp_last;
    logic       b_nz;
    logic       f_past;
    logic       f_hit;
    logic       e_go;
    logic       pend;
    logic       out_free;
    logic       clr_last;
  } status_t;

endpackage

### hw/rtl/mlhs_ctrl.sv
module mlhs_ctrl import mlhs_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  status_t status_i,
  output cmd_t    cmd_o,
  output logic    in_stall_o
);

  localparam logic [4:0] S_CLR    = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_CDISP  = 5'd2;
  localparam logic [4:0] S_SC_RD  = 5'd3;
  localparam logic [4:0] S_SC_EV  = 5'd4;
  localparam logic [4:0] S_SH_CHK = 5'd5;
  localparam logic [4:0] S_SH_RD  = 5'd6;
  localparam logic [4:0] S_SH_WR  = 5'd7;
  localparam logic [4:0] S_ZT     = 5'd8;
  localparam logic [4:0] S_ZS     = 5'd9;
  localparam logic [4:0] S_CP_RD  = 5'd10;
  localparam logic [4:0] S_CP_WR  = 5'd11;
  localparam logic [4:0] S_CRES   = 5'd12;
  localparam logic [4:0] S_FDISP  = 5'd13;
  localparam logic [4:0] S_F_RD   = 5'd14;
  localparam logic [4:0] S_F_EV   = 5'd15;
  localparam logic [4:0] S_FNF    = 5'd16;
  localparam logic [4:0] S_E_RD   = 5'd17;
  localparam logic [4:0] S_E_EV   = 5'd18;

  logic [4:0] state_q, state_d;
  op_e        op;

  always_comb begin
    state_d = state_q;
    op      = OP_NOP;
    case (state_q)
      S_CLR: begin
        op = OP_CLR;
        if (status_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          op = OP_LATCH;
          if (status_i.req == REQ_COMMIT) state_d = S_CDISP;
          else if (status_i.req == REQ_FETCH) state_d = S_FDISP;
        end
      end
      S_CDISP: begin
        if (status_i.slen_zero) begin
          state_d = S_CRES;
        end else if (status_i.fill_zero) begin
          op      = OP_INS_INIT;
          state_d = S_SH_CHK;
        end else begin
          op      = OP_SC_INIT;
          state_d = S_SC_RD;
        end
      end
      S_SC_RD: begin
        op      = OP_SC_RD;
        state_d = S_SC_EV;
      end
      S_SC_EV: begin
        if (status_i.sc_match) begin
          op      = OP_DUP_INIT;
          state_d = S_SH_CHK;
        end else if (status_i.sc_end) begin
          op      = OP_INS_INIT;
          state_d = S_SH_CHK;
        end else begin
          op      = OP_SC_EV;
          state_d = S_SC_RD;
        end
      end
      S_SH_CHK: begin
        if (status_i.sh_go) state_d = S_SH_RD;
        else if (status_i.dup) state_d = S_ZS;
        else state_d = S_ZT;
      end
      S_SH_RD: begin
        op      = OP_SH_RD;
        state_d = S_SH_WR;
      end
      S_SH_WR: begin
        op = OP_SH_WR;
        if (!status_i.sh_last) state_d = S_SH_RD;
        else if (status_i.dup) state_d = S_ZS;
        else state_d = S_ZT;
      end
      S_ZT: begin
        op      = OP_ZT;
        state_d = S_ZS;
      end
      S_ZS: begin
        op      = OP_ZS;
        state_d = S_CP_RD;
      end
      S_CP_RD: begin
        op      = OP_CP_RD;
        state_d = S_CP_WR;
      end
      S_CP_WR: begin
        op      = OP_CP_WR;
        state_d = status_i.cp_last ? S_CRES : S_CP_RD;
      end
      S_CRES: begin
        if (status_i.out_free) begin
          op      = OP_C_RES;
          state_d = S_IDLE;
        end
      end
      S_FDISP: begin
        if (status_i.fill_zero) begin
          state_d = S_FNF;
        end else begin
          op      = OP_F_INIT;
          state_d = status_i.idx_zero ? S_E_RD : S_F_RD;
        end
      end
      S_F_RD: begin
        op      = OP_RD_P;
        state_d = S_F_EV;
      end
      S_F_EV: begin
        if (status_i.b_nz) begin
          op      = OP_P_INC;
          state_d = S_F_RD;
        end else begin
          op = OP_F_NEXT;
          if (status_i.f_past) state_d = S_FNF;
          else if (status_i.f_hit) state_d = S_E_RD;
          else state_d = S_F_RD;
        end
      end
      S_FNF: begin
        if (status_i.out_free) begin
          op      = OP_NF_RES;
          state_d = S_IDLE;
        end
      end
      S_E_RD: begin
        op      = OP_RD_P;
        state_d = S_E_EV;
      end
      S_E_EV: begin
        if (status_i.e_go && !status_i.pend) begin
          op      = OP_E_TAKE;
          state_d = S_E_RD;
        end else if (status_i.e_go) begin
          if (status_i.out_free) begin
            op      = OP_E_PUSH;
            state_d = S_E_RD;
          end
        end else if (status_i.out_free) begin
          op      = status_i.pend ? OP_E_LAST : OP_E_EMPTY;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  assign cmd_o.op   = op;
  assign in_stall_o = (state_q != S_IDLE);

endmodule

### hw/rtl/mlhs_dp.sv
module mlhs_dp import mlhs_pkg::*; #(
  parameter int unsigned HISTORY_BYTES = HistoryBytesDef,
  parameter int unsigned LINE_MAX      = LineMaxDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_t       cmd_i,
  output status_t    status_o,
  input  in_item_t   in_data_i,
  input  logic       cfg_valid_i,
  input  logic [6:0] cfg_wdata_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_item_t  out_data_o
);

  localparam int unsigned AW  = $clog2(HISTORY_BYTES);
  localparam int unsigned PW  = $clog2(HISTORY_BYTES + 1);
  localparam int unsigned LW  = $clog2(LINE_MAX);
  localparam int unsigned LCW = $clog2(LINE_MAX + 1);
  localparam int unsigned XW  = ((PW > LCW) ? PW : LCW) + 1;
  localparam int unsigned CW  = (LCW > 7) ? LCW : 7;

  logic [6:0] mem  [HISTORY_BYTES];
  logic [6:0] smem [LINE_MAX];

  logic [6:0]     cap_q, cap_d;
  logic [LCW-1:0] slen_q, slen_d;
  logic [PW-1:0]  fill_q, fill_d;
  logic           ovalid_q, ovalid_d;
  logic [AW-1:0]  clr_q, clr_d;
  logic           pend_q, pend_d;
  logic [8:0]     idx_q, idx_d;
  logic [PW-1:0]  p_q, p_d, s_q, s_d, j_q, j_d, nl_q, nl_d;
  logic           mis_q, mis_d, dup_q, dup_d;
  logic [AW-1:0]  q_q, q_d;
  logic [LW-1:0]  i_q, i_d;
  logic [8:0]     hn_q, hn_d;
  logic [5:0]     k_q, k_d;
  logic [6:0]     pbyte_q, pbyte_d;
  out_item_t      out_q, out_d;
  logic [6:0]     rd_q, srd_q;

  logic           we, re, swe, sre;
  logic [AW-1:0]  wa, ra;
  logic [6:0]     wd;
  logic [LW-1:0]  swa, sra;

  logic [CW-1:0]  eff_cap;
  logic [5:0]     lim;
  logic [XW-1:0]  j_x, slen_x, nl_x, q_x, i_x;
  logic [PW:0]    fsum;
  logic           out_free, emit;

  assign j_x    = XW'(j_q);
  assign slen_x = XW'(slen_q);
  assign nl_x   = XW'(nl_q);
  assign q_x    = XW'(q_q);
  assign i_x    = XW'(i_q);
  assign fsum   = (PW + 1)'(fill_q) + (PW + 1)'(nl_q);

  always_comb begin
    eff_cap = (CW'(cap_q) < CW'(LINE_MAX)) ? CW'(cap_q) : CW'(LINE_MAX);
    if (eff_cap == '0) lim = '0;
    else if ((eff_cap - CW'(1)) > CW'(MaxResults)) lim = 6'(MaxResults);
    else lim = 6'(eff_cap - CW'(1));
  end

  assign out_free = !ovalid_q || !out_stall_i;
  assign emit = (cmd_i.op == OP_C_RES) || (cmd_i.op == OP_NF_RES) ||
                (cmd_i.op == OP_E_PUSH) || (cmd_i.op == OP_E_LAST) ||
                (cmd_i.op == OP_E_EMPTY);

  always_comb begin
    status_o.req       = in_data_i.req_type;
    status_o.slen_zero = (slen_q == '0);
    status_o.fill_zero = (fill_q == '0);
    status_o.idx_zero  = (idx_q == '0);
    status_o.sc_match  = (rd_q == '0) && !mis_q && (j_x == slen_x);
    status_o.sc_end    = (p_q == PW'(HISTORY_BYTES - 1));
    status_o.sh_go     = (q_x >= nl_x);
    status_o.sh_last   = (q_x == nl_x);
    status_o.dup       = dup_q;
    status_o.cp_last   = ((i_x + XW'(1)) == (nl_x - XW'(1)));
    status_o.b_nz      = (rd_q != '0);
    status_o.f_past    = ((PW + 1)'(p_q) + (PW + 1)'(1)) >= (PW + 1)'(fill_q);
    status_o.f_hit     = ((hn_q + 9'd1) == idx_q);
    status_o.e_go      = (k_q < lim) && (p_q < PW'(HISTORY_BYTES)) && (rd_q != '0);
    status_o.pend      = pend_q;
    status_o.out_free  = out_free;
    status_o.clr_last  = (clr_q == AW'(HISTORY_BYTES - 1));
  end

  always_comb begin
    cap_d   = cap_q;
    slen_d  = slen_q;
    fill_d  = fill_q;
    ovalid_d = ovalid_q && out_stall_i;
    clr_d   = clr_q;
    pend_d  = pend_q;
    idx_d   = idx_q;
    p_d     = p_q;
    s_d     = s_q;
    j_d     = j_q;
    nl_d    = nl_q;
    mis_d   = mis_q;
    dup_d   = dup_q;
    q_d     = q_q;
    i_d     = i_q;
    hn_d    = hn_q;
    k_d     = k_q;
    pbyte_d = pbyte_q;
    out_d   = out_q;
    we = 1'b0; wa = '0; wd = '0; re = 1'b0; ra = '0;
    swe = 1'b0; swa = '0; sre = 1'b0; sra = '0;

    if (cfg_valid_i) cap_d = cfg_wdata_i;

    case (cmd_i.op)
      OP_CLR: begin
        we = 1'b1; wa = clr_q; clr_d = clr_q + AW'(1);
      end
      OP_LATCH: begin
        idx_d = in_data_i.entry_index;
        if (in_data_i.req_type == REQ_STAGE && in_data_i.line_byte != '0 &&
            CW'(slen_q) < eff_cap) begin
          swe    = 1'b1;
          swa    = slen_q[LW-1:0];
          slen_d = slen_q + LCW'(1);
        end
      end
      OP_SC_INIT: begin
        p_d = '0; s_d = '0; j_d = '0; mis_d = 1'b0;
      end
      OP_SC_RD: begin
        re = 1'b1; ra = p_q[AW-1:0];
        sre = 1'b1; sra = j_x[LW-1:0];
      end
      OP_SC_EV: begin
        if (rd_q == '0) begin
          s_d = p_q + PW'(1); j_d = '0; mis_d = 1'b0;
        end else begin
          j_d   = j_q + PW'(1);
          mis_d = mis_q || (j_x >= slen_x) || (rd_q != srd_q);
        end
        p_d = p_q + PW'(1);
      end
      OP_DUP_INIT: begin
        nl_d  = PW'(slen_x + XW'(1));
        q_d   = AW'(XW'(s_q) + slen_x - XW'(1));
        dup_d = 1'b1;
      end
      OP_INS_INIT: begin
        nl_d  = ((slen_x + XW'(1)) > XW'(HISTORY_BYTES)) ? PW'(HISTORY_BYTES)
                                                        : PW'(slen_x + XW'(1));
        q_d   = AW'(HISTORY_BYTES - 1);
        dup_d = 1'b0;
      end
      OP_SH_RD: begin
        re = 1'b1; ra = AW'(PW'(q_q) - nl_q);
      end
      OP_SH_WR: begin
        we = 1'b1; wa = q_q; wd = rd_q; q_d = q_q - AW'(1);
      end
      OP_ZT: begin
        we = 1'b1; wa = AW'(HISTORY_BYTES - 1);
      end
      OP_ZS: begin
        we = 1'b1; wa = AW'(nl_q - PW'(1)); i_d = '0;
      end
      OP_CP_RD: begin
        sre = 1'b1; sra = i_q;
      end
      OP_CP_WR: begin
        we = 1'b1; wa = AW'(i_q); wd = srd_q; i_d = i_q + LW'(1);
      end
      OP_C_RES: begin
        out_d.out_byte = '0;
        out_d.found    = 1'b0;
        out_d.last     = 1'b1;
        if (slen_q == '0) begin
          out_d.commit_status = ST_EMPTY;
        end else if (dup_q) begin
          out_d.commit_status = ST_DUP;
        end else begin
          out_d.commit_status = ST_INS;
          fill_d = (fsum > (PW + 1)'(HISTORY_BYTES)) ? PW'(HISTORY_BYTES) : PW'(fsum);
        end
        slen_d   = '0;
        ovalid_d = 1'b1;
      end
      OP_F_INIT: begin
        p_d = '0; hn_d = '0; k_d = '0; pend_d = 1'b0;
      end
      OP_RD_P: begin
        re = 1'b1; ra = p_q[AW-1:0];
      end
      OP_P_INC: p_d = p_q + PW'(1);
      OP_F_NEXT: begin
        p_d  = p_q + PW'(1);
        hn_d = hn_q + 9'd1;
      end
      OP_NF_RES: begin
        out_d    = '{out_byte: '0, found: 1'b0, commit_status: ST_EMPTY, last: 1'b1};
        ovalid_d = 1'b1;
      end
      OP_E_TAKE: begin
        pbyte_d = rd_q; pend_d = 1'b1;
        k_d = k_q + 6'd1; p_d = p_q + PW'(1);
      end
      OP_E_PUSH: begin
        out_d    = '{out_byte: pbyte_q, found: 1'b1, commit_status: ST_EMPTY, last: 1'b0};
        ovalid_d = 1'b1;
        pbyte_d  = rd_q;
        k_d = k_q + 6'd1; p_d = p_q + PW'(1);
      end
      OP_E_LAST: begin
        out_d    = '{out_byte: pbyte_q, found: 1'b1, commit_status: ST_EMPTY, last: 1'b1};
        ovalid_d = 1'b1;
        pend_d   = 1'b0;
      end
      OP_E_EMPTY: begin
        out_d    = '{out_byte: '0, found: 1'b1, commit_status: ST_EMPTY, last: 1'b1};
        ovalid_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q    <= CapReset;
      slen_q   <= '0;
      fill_q   <= '0;
      ovalid_q <= 1'b0;
      clr_q    <= '0;
      pend_q   <= 1'b0;
    end else begin
      cap_q    <= cap_d;
      slen_q   <= slen_d;
      fill_q   <= fill_d;
      ovalid_q <= ovalid_d;
      clr_q    <= clr_d;
      pend_q   <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    p_q     <= p_d;
    s_q     <= s_d;
    j_q     <= j_d;
    nl_q    <= nl_d;
    mis_q   <= mis_d;
    dup_q   <= dup_d;
    q_q     <= q_d;
    i_q     <= i_d;
    hn_q    <= hn_d;
    k_q     <= k_d;
    pbyte_q <= pbyte_d;
    out_q   <= out_d;
  end

  // history store: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    if (re) rd_q <= mem[ra];
  end

  // staged line buffer
  always_ff @(posedge clk_i) begin
    if (swe) smem[swa] <= in_data_i.line_byte;
    if (sre) srd_q <= smem[sra];
  end

  assign out_valid_o = ovalid_q;
  assign out_data_o  = out_q;

  // a result only lands in the output register once it is free
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> out_free) else $error("result overwrites a pending item");

  // shift source never runs below the front of the store
  a_shift_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_SH_RD) |-> (q_x >= nl_x)) else $error("shift past front");

  a_fetch_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((cmd_i.op == OP_E_TAKE) || (cmd_i.op == OP_E_PUSH)) |-> (k_q < lim))
    else $error("fetch exceeds line capacity");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_C_RES) |=> (fill_q <= PW'(HISTORY_BYTES)) && (slen_q == '0))
    else $error("fill or staged length out of range after commit");

endmodule

### hw/rtl/mru_line_history_store.sv
// channel | direction | handshake             | payload
// in      | input     | in_valid_i/in_stall_o  | in_data_i (in_item_t)
// out     | output    | out_valid_o/out_stall_i| out_data_o (out_item_t)
// cfg     | input     | cfg_valid_i/cfg_ready_o| cfg_wdata_i (line capacity)
//
// After reset a clearing pass zeroes the store; no item is taken meanwhile.
// Stage is taken in the idle state. Commit scans up to HISTORY_BYTES store bytes for a
// duplicate, then shifts bytes and writes the line bytes; the single store port sets its pace.
// Fetch reads the store byte by byte while skipping or returning, and waits on output stalls.
// One item at a time; the final result waits in the output register while the
// next item is taken.
module mru_line_history_store import mlhs_pkg::*; #(
  parameter int unsigned HISTORY_BYTES = HistoryBytesDef,
  parameter int unsigned LINE_MAX      = LineMaxDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_item_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_item_t  out_data_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [6:0] cfg_wdata_i
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  mlhs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (status),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  mlhs_dp #(
    .HISTORY_BYTES (HISTORY_BYTES),
    .LINE_MAX      (LINE_MAX)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import mlhs_pkg::*;

  localparam int HistBytes = 512;
  localparam int LineMax   = 64;

  // Holds the software copy of the history and the queue of due results.
  class history_scoreboard;
    bit [6:0]  store [HistBytes];
    int        fill;
    bit [6:0]  staged [LineMax];
    int        staged_len;
    int        capacity;
    out_item_t due_q [$];
    int        errors;

    function void clear();
      foreach (store[i]) store[i] = '0;
      fill = 0;
      staged_len = 0;
      capacity = 64;
      due_q.delete();
      errors = 0;
    endfunction

    function int eff_cap();
      return (capacity < LineMax) ? capacity : LineMax;
    endfunction

    function void push(bit [6:0] b, bit f, bit [1:0] st, bit l);
      out_item_t r;
      r.out_byte = b;
      r.found = f;
      r.commit_status = st;
      r.last = l;
      due_q.push_back(r);
    endfunction

    function bit move_dup(int len);
      int s, e, q, i;
      bit same;
      s = 0;
      if (fill == 0) return 0;
      while (s < HistBytes) begin
        e = s;
        while (e < HistBytes - 1 && store[e] != 0) e++;
        if (e - s == len) begin
          same = 1;
          for (i = 0; i < len; i++) if (store[s + i] != staged[i]) same = 0;
          if (same) begin
            for (q = s + len - 1; q > len; q--) store[q] = store[q - len - 1];
            store[len] = '0;
            for (i = 0; i < len; i++) store[i] = staged[i];
            return 1;
          end
        end
        s = e + 1;
      end
      return 0;
    endfunction

    function bit [1:0] commit_line();
      int nl, i;
      if (staged_len == 0) return ST_EMPTY;
      if (move_dup(staged_len)) return ST_DUP;
      nl = staged_len + 1;
      if (nl > HistBytes) nl = HistBytes;
      for (i = HistBytes - 1; i >= nl; i--) store[i] = store[i - nl];
      store[HistBytes - 1] = '0;
      store[nl - 1] = '0;
      for (i = 0; i + 1 < nl; i++) store[i] = staged[i];
      fill += nl;
      if (fill > HistBytes) fill = HistBytes;
      return ST_INS;
    endfunction

    function void fetch(int n);
      int p, hn, lim, k;
      p = 0;
      k = 0;
      if (fill == 0) begin
        push(0, 0, ST_EMPTY, 1);
        return;
      end
      for (hn = 0; hn < n; hn++) begin
        while (p < HistBytes && store[p] != 0) p++;
        p++;
        if (p >= fill) begin
          push(0, 0, ST_EMPTY, 1);
          return;
        end
      end
      lim = eff_cap() > 0 ? eff_cap() - 1 : 0;
      if (lim > MaxResults) lim = MaxResults;
      while (k < lim && p < HistBytes && store[p] != 0) begin
        push(store[p], 1, ST_EMPTY, 0);
        k++;
        p++;
      end
      if (k == 0) push(0, 1, ST_EMPTY, 1);
      else due_q[$].last = 1;
    endfunction

    function void note_input(in_item_t it);
      case (it.req_type)
        REQ_STAGE: begin
          if (it.line_byte != 0 && staged_len < eff_cap()) begin
            staged[staged_len] = it.line_byte;
            staged_len++;
          end
        end
        REQ_COMMIT: begin
          push(0, 0, commit_line(), 1);
          staged_len = 0;
        end
        REQ_FETCH: fetch(it.entry_index);
        default: ;
      endcase
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_r;
      if (due_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp_r = due_q.pop_front();
      if (got !== exp_r) begin
        $display("%0t: mismatch expected byte=%h found=%b st=%h last=%b,",
                 $time, exp_r.out_byte, exp_r.found, exp_r.commit_status, exp_r.last);
        $display("%0t:          got byte=%h found=%b st=%h last=%b",
                 $time, got.out_byte, got.found, got.commit_status, got.last);
        errors++;
      end
    endfunction
  endclass

  logic       clk_i = 0;
  logic       rst_ni = 0;
  logic       in_valid_i = 0;
  logic       in_stall_o;
  in_item_t   in_data_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 0;
  out_item_t  out_data_o;
  logic       cfg_valid_i = 0;
  logic       cfg_ready_o;
  logic [6:0] cfg_wdata_i = '0;

  history_scoreboard hist_sb;
  bit stall_quiet;

  always begin
    #4 clk_i = 1;
    #4 clk_i = 0;
  end

  mru_line_history_store u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_wdata_i
  );

  // output side: check on accept
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) hist_sb.check_result(out_data_o);
  end

  // output side: stall a drawn number of cycles before taking each item
  initial begin
    int w;
    forever begin
      w = stall_quiet ? 0 : $urandom_range(0, 18);
      if (w > 0) begin
        out_stall_i <= 1'b1;
        repeat (w) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(rst_ni && out_valid_o));
    end
  end

  task automatic send_item(bit [1:0] rq, bit [6:0] b, bit [8:0] idx);
    in_item_t it;
    int gap;
    it.req_type = rq;
    it.line_byte = b;
    it.entry_index = idx;
    gap = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 18) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    hist_sb.note_input(it);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (hist_sb.due_q.size() != 0) @(posedge clk_i);
    repeat (2400) @(posedge clk_i);
  endtask

  task automatic write_cap(bit [6:0] v);
    cfg_valid_i <= 1'b1;
    cfg_wdata_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    hist_sb.capacity = v;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic stage_line(int len, int alpha);
    repeat (len) send_item(REQ_STAGE, 7'($urandom_range(1, alpha)), 9'($urandom));
  endtask

  task automatic random_phase(int count);
    int k, r;
    for (k = 0; k < count; k++) begin
      r = $urandom_range(0, 9);
      if (r < 4) begin
        stage_line($urandom_range(1, 4), 3);
        send_item(REQ_COMMIT, 7'($urandom), 9'($urandom));
      end else if (r < 8) begin
        send_item(REQ_FETCH, 7'($urandom),
                  ($urandom_range(0, 4) == 0) ? 9'($urandom) : 9'($urandom_range(0, 12)));
      end else if (r == 8) begin
        send_item(REQ_STAGE, ($urandom_range(0, 3) == 0) ? 7'd0 : 7'($urandom), 9'($urandom));
      end else begin
        send_item(2'd3, 7'($urandom), 9'($urandom));
      end
    end
  endtask

  initial begin
    hist_sb = new();
    hist_sb.clear();
    stall_quiet = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: empty store, empty commit, extremes
    send_item(REQ_FETCH, 7'd0, 9'd0);
    send_item(REQ_COMMIT, 7'd0, 9'd0);
    send_item(REQ_STAGE, 7'd0, 9'd511);
    send_item(REQ_STAGE, 7'd127, 9'd0);
    send_item(REQ_STAGE, 7'd1, 9'd0);
    send_item(REQ_COMMIT, 7'd127, 9'd511);
    send_item(REQ_FETCH, 7'd127, 9'd0);
    send_item(REQ_FETCH, 7'd0, 9'd511);
    send_item(2'd3, 7'd127, 9'd511);
    stage_line(70, 127);   // over capacity, bytes dropped
    send_item(REQ_COMMIT, 7'd0, 9'd0);
    send_item(REQ_FETCH, 7'd0, 9'd0);
    send_item(REQ_STAGE, 7'd127, 9'd0);
    send_item(REQ_STAGE, 7'd1, 9'd0);
    send_item(REQ_COMMIT, 7'd0, 9'd0); // duplicate
    send_item(REQ_FETCH, 7'd0, 9'd1);
    drain();
    write_cap(7'd2);
    send_item(REQ_FETCH, 7'd0, 9'd0);
    drain();
    write_cap(7'd127);
    send_item(REQ_FETCH, 7'd0, 9'd1);
    random_phase(15);
    drain();
    write_cap(7'd0);
    random_phase(8);
    drain();
    write_cap(7'd5);
    random_phase(15);
    drain();
    write_cap(7'd64);
    random_phase(17);
    stall_quiet = 1;
    random_phase(5);
    drain();
    if (hist_sb.errors == 0 && hist_sb.due_q.size() == 0) begin
      $display("** mru_line_history_store: PASSED **");
    end else begin
      $display("** mru_line_history_store: FAILED **");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("** mru_line_history_store: FAILED **");
    $finish;
  end

endmodule
